[hw/rtl/scc_pkg.sv]
// Shared types and constants for the sequence cross-correlation unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package scc_pkg;

    // Fixed field widths of the request and result channels.
    localparam int SAMPLE_IN_W = 16;
    localparam int VALUE_W     = 37;
    localparam int LAG_IDX_W   = 6;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_LEN      = 32;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Configuration port geometry and register map.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_CORR_MODE_ADDR = 3'd0;

    // Correlation modes; the unused code behaves as full.
    localparam logic [1:0] MODE_VALID = 2'd0;
    localparam logic [1:0] MODE_SAME  = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;

    // Request types.
    localparam logic REQ_SEQ_A = 1'b0;
    localparam logic REQ_SEQ_V = 1'b1;

    // One input request.
    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_IN_W-1:0] sample;
        logic                          seq_last;
    } t_in_item;

    // One result of the output run.
    typedef struct packed {
        logic signed [VALUE_W-1:0] corr_value;
        logic [LAG_IDX_W-1:0]      lag_index;
        logic                      run_last;
        logic                      truncated;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;    // store the accepted request
        logic setup;      // derive the lag window from lengths and mode
        logic lag_start;  // clear the accumulator and the element counter
        logic mac_issue;  // read one element pair and step the counter
        logic out_load;   // capture the finished sum in the output register
        logic next_lag;   // advance to the following lag
        logic clear;      // drop lengths and flags after the run
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_done;  // both sequences have seen their last mark
        logic j_last;     // the element counter is at the last stored a element
        logic pipe_busy;  // products still in flight toward the accumulator
        logic lag_last;   // the current lag is the final one of the run
        logic out_taken;  // the pending result is taken this cycle
    } t_dp_status;

endpackage

[hw/rtl/scc_in_if.sv]
// Request channel of the sequence cross-correlation unit.
// Depends on scc_pkg for the request payload type.
interface scc_in_if
    import scc_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/scc_out_if.sv]
// Result channel of the sequence cross-correlation unit.
// Depends on scc_pkg for the result payload type.
interface scc_out_if
    import scc_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/sequence_cross_correlation_unit.sv]
// Top level of the sequence cross-correlation unit: configuration register,
// controller and datapath. Depends on scc_pkg, scc_in_if, scc_out_if,
// scc_ctrl and scc_dpath.
//
// Requests load the a and v sequences one element per cycle; each sequence
// ends at its last mark, and elements beyond MAX_LEN are dropped and flag
// the run as truncated. Once the request that completes the second sequence
// is taken, the unit computes the run one lag at a time on a single shared
// multiply-accumulate unit that reads one a sample and one v sample per
// cycle; each result is then held until the sink takes it. No requests are
// taken from the completing request until the final result of the run is
// taken. The stores need no clearing pass after reset. corr_mode sits at
// byte address 0 and is to be written only while idle; the block itself
// does not enforce this.
module sequence_cross_correlation_unit
    import scc_pkg::*;
#(
    parameter int MAX_LEN      = DEF_MAX_LEN,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scc_in_if.sink                i_in,
    scc_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [1:0]  r_corr_mode;
    t_ctrl_cmd   cmd;
    t_dp_status  status;
    logic        in_ready;
    logic        cfg_wr;

    // Configuration register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_mode <= MODE_VALID;
        end else if (cfg_wr && (paddr == REG_CORR_MODE_ADDR)) begin
            r_corr_mode <= pwdata[1:0];
        end
    end

    // Register readback.
    always_comb begin
        case (paddr)
            REG_CORR_MODE_ADDR: prdata = APB_DATA_W'(r_corr_mode);
            default:            prdata = '0;
        endcase
    end

    // Controller.
    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Datapath.
    scc_dpath #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (r_corr_mode),
        .i_in_item   (i_in.payload),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload),
        .o_status    (status)
    );

    // A result never waits while requests are being taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("result pending while requests are taken");

    // Once the final result is taken, nothing follows at once.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.payload.run_last) |=> !o_out.valid)
        else $error("result presented right after the end of a run");

    // A taken result is followed by lag computation before the next result.
    a_lag_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> !o_out.valid)
        else $error("next lag presented without accumulation");

endmodule

[hw/rtl/scc_ctrl.sv]
// Controller state machine of the sequence cross-correlation unit.
// Sequences loading, lag setup, the multiply-accumulate sweep and result hand-off.
// Depends on scc_pkg for the command and status structs.
module scc_ctrl
    import scc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_LAG,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state;

    // Requests are taken only while loading and before both sequences are complete.
    assign o_in_ready = (r_state == S_LOAD) && !i_status.both_done;

    // Command decode.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_en   = o_in_ready && i_in_valid;
        o_cmd.setup     = (r_state == S_SETUP);
        o_cmd.lag_start = (r_state == S_LAG);
        o_cmd.mac_issue = (r_state == S_MAC);
        o_cmd.out_load  = (r_state == S_DRAIN) && !i_status.pipe_busy;
        o_cmd.next_lag  = (r_state == S_OUT) && i_status.out_taken && !i_status.lag_last;
        o_cmd.clear     = (r_state == S_OUT) && i_status.out_taken && i_status.lag_last;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_status.both_done) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= S_LAG;
                end
                S_LAG: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (i_status.j_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!i_status.pipe_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_status.out_taken) begin
                        r_state <= i_status.lag_last ? S_LOAD : S_LAG;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

[hw/rtl/scc_dpath.sv]
// Datapath of the sequence cross-correlation unit: sample stores, lengths,
// lag window, the shared multiply-accumulate pipeline and the output register.
// Depends on scc_pkg for payload, command and status types.
module scc_dpath
    import scc_pkg::*;
#(
    parameter int MAX_LEN      = DEF_MAX_LEN,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  logic [1:0] i_mode,
    input  t_in_item   i_in_item,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_item  o_out_item,
    output t_dp_status o_status
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int LAG_W  = $clog2(2 * MAX_LEN);
    localparam int VI_W   = LAG_W + 2;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int EXT_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

    // Sample stores.
    logic signed [SAMPLE_WIDTH-1:0] mem_a [MAX_LEN];
    logic signed [SAMPLE_WIDTH-1:0] mem_v [MAX_LEN];

    // Sequence bookkeeping.
    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_v;
    logic              r_done_a;
    logic              r_done_v;
    logic              r_ovf;

    // Lag window and sweep counters.
    logic [LAG_W-1:0]  r_k;
    logic [LAG_W-1:0]  r_m;
    logic [LAG_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_j;

    // Multiply-accumulate pipeline.
    logic signed [SAMPLE_WIDTH-1:0] r_rd_a;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_v;
    logic                           r_p1_vld;
    logic                           r_p1_hit;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_p2_vld;
    logic [VALUE_W-1:0]             r_acc;

    // Output register.
    logic      r_out_vld;
    t_out_item r_out_item;

    logic [SAMPLE_WIDTH-1:0] in_sample;
    logic                    cnt_a_room;
    logic                    cnt_v_room;
    logic [LAG_W-1:0]        la;
    logic [LAG_W-1:0]        lv;
    logic [LAG_W-1:0]        n1;
    logic [LAG_W-1:0]        n2;
    logic [LAG_W-1:0]        nleft;
    logic [LAG_W-1:0]        n_start;
    logic [LAG_W-1:0]        n_len;
    logic signed [VI_W-1:0]  vi;
    logic                    vi_hit;
    logic [ADDR_W-1:0]       v_addr;
    logic signed [PROD_W-1:0] mul;
    logic signed [EXT_W-1:0]  prod_ext;
    logic                     out_taken;

    // The low SAMPLE_WIDTH bits of the request sample form the stored value.
    assign in_sample  = SAMPLE_WIDTH'($unsigned(i_in_item.sample));
    assign cnt_a_room = (r_cnt_a < CNT_W'(MAX_LEN));
    assign cnt_v_room = (r_cnt_v < CNT_W'(MAX_LEN));

    // Store writes while loading; elements beyond the store depth are dropped.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            if (i_in_item.req_type == REQ_SEQ_A) begin
                if (!r_done_a && cnt_a_room) begin
                    mem_a[r_cnt_a[ADDR_W-1:0]] <= in_sample;
                end
            end else begin
                if (!r_done_v && cnt_v_room) begin
                    mem_v[r_cnt_v[ADDR_W-1:0]] <= in_sample;
                end
            end
        end
    end

    // Lengths, last marks and the overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_v  <= '0;
            r_done_a <= 1'b0;
            r_done_v <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.clear) begin
            r_cnt_a  <= '0;
            r_cnt_v  <= '0;
            r_done_a <= 1'b0;
            r_done_v <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.load_en) begin
            if (i_in_item.req_type == REQ_SEQ_A) begin
                if (!r_done_a) begin
                    if (cnt_a_room) begin
                        r_cnt_a <= r_cnt_a + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (i_in_item.seq_last) begin
                        r_done_a <= 1'b1;
                    end
                end
            end else begin
                if (!r_done_v) begin
                    if (cnt_v_room) begin
                        r_cnt_v <= r_cnt_v + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (i_in_item.seq_last) begin
                        r_done_v <= 1'b1;
                    end
                end
            end
        end
    end

    // Lag window from the stored lengths and the mode.
    assign la    = LAG_W'(r_cnt_a);
    assign lv    = LAG_W'(r_cnt_v);
    assign n1    = (la > lv) ? la : lv;
    assign n2    = (la > lv) ? lv : la;
    assign nleft = n2 >> 1;

    always_comb begin
        case (i_mode)
            MODE_VALID: begin
                n_start = n2 - 1'b1;
                n_len   = n1 - n2 + 1'b1;
            end
            MODE_SAME: begin
                n_start = (la < lv) ? nleft : (n2 - 1'b1 - nleft);
                n_len   = n1;
            end
            default: begin
                n_start = '0;
                n_len   = la + lv - 1'b1;
            end
        endcase
    end

    // Lag and run position counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_k   <= n_start;
            r_m   <= '0;
            r_len <= n_len;
        end else if (i_cmd.next_lag) begin
            r_k <= r_k + 1'b1;
            r_m <= r_m + 1'b1;
        end
    end

    // Element counter over the stored a sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lag_start) begin
            r_j <= '0;
        end else if (i_cmd.mac_issue) begin
            r_j <= r_j + 1'b1;
        end
    end

    // Partner index in v for element j of a at lag k: j - k + Lv - 1.
    assign vi     = $signed(VI_W'(r_j)) - $signed(VI_W'(r_k))
                  + $signed(VI_W'(r_cnt_v)) - $signed(VI_W'(1));
    assign vi_hit = (vi >= 0) && (vi < $signed(VI_W'(r_cnt_v)));
    assign v_addr = vi[ADDR_W-1:0];

    // Stage one: registered reads from both stores.
    always_ff @(posedge i_clk) begin
        r_rd_a   <= mem_a[r_j];
        r_rd_v   <= mem_v[v_addr];
        r_p1_hit <= vi_hit;
    end

    // Stage two: product, zero for pairs outside the overlap.
    assign mul = r_rd_a * r_rd_v;

    always_ff @(posedge i_clk) begin
        r_prod <= r_p1_hit ? mul : '0;
    end

    // Pipeline occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.mac_issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    // Accumulator wraps to the result width.
    assign prod_ext = EXT_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.lag_start) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + prod_ext[VALUE_W-1:0];
        end
    end

    // Output register; held until the sink takes it.
    assign out_taken = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (out_taken) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.corr_value <= $signed(r_acc);
            r_out_item.lag_index  <= LAG_IDX_W'(r_m);
            r_out_item.run_last   <= o_status.lag_last;
            r_out_item.truncated  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Status to the controller.
    always_comb begin
        o_status           = '0;
        o_status.both_done = r_done_a && r_done_v;
        o_status.j_last    = (CNT_W'(r_j) == (r_cnt_a - 1'b1));
        o_status.pipe_busy = r_p1_vld || r_p2_vld;
        o_status.lag_last  = (r_m == (r_len - 1'b1));
        o_status.out_taken = out_taken;
    end

endmodule

[sim/sequence_cross_correlation_unit_tb.sv]
// Self-checking testbench for the sequence cross-correlation unit: directed pairs, overflow
// and random pairs under four pacing mixes, each result checked against a local predictor.
// Depends on scc_pkg, scc_in_if, scc_out_if and sequence_cross_correlation_unit.
module sequence_cross_correlation_unit_tb;
    import scc_pkg::*;

    localparam int MAX_LEN = DEF_MAX_LEN;
    localparam int CLK_HALF = 4;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int MAX_PRINTED = 40;
    // The fourth mode code has no name in the package; it must act as full.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    scc_in_if  in_if ();
    scc_out_if out_if ();

    sequence_cross_correlation_unit #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (DEF_SAMPLE_WIDTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the two sample stores, lengths, end marks and the mode.
    logic signed [SAMPLE_IN_W-1:0] samples_a [MAX_LEN];
    logic signed [SAMPLE_IN_W-1:0] samples_v [MAX_LEN];
    int         len_a = 0;
    int         len_v = 0;
    bit         ended_a = 1'b0;
    bit         ended_v = 1'b0;
    bit         dropped_any = 1'b0;
    logic [1:0] cur_mode = MODE_VALID;

    t_out_item exp_corr_q[$];

    int err_count = 0;
    int req_count = 0;
    int result_count = 0;
    int run_count = 0;
    int trunc_run_count = 0;
    int src_gap_pct = 0;
    int snk_stall_pct = 0;

    // One line per mismatch, with printing capped so a broken build stays readable.
    task automatic report_mismatch(input string what, input int lag, input longint got,
                                   input longint want);
        if (err_count < MAX_PRINTED) begin
            $display("MISMATCH %s at lag %0d: got %0d, expected %0d (t=%0t)",
                     what, lag, got, want, $time);
        end
        err_count++;
    endtask

    // Correlation run of the current pair: every lag of the selected window, in order.
    function automatic void emit_corr_run();
        int        n1;
        int        n2;
        int        first_lag;
        int        run_len;
        int        m;
        int        j;
        int        vi;
        longint    acc;
        t_out_item r;
        n1 = (len_a > len_v) ? len_a : len_v;
        n2 = (len_a > len_v) ? len_v : len_a;
        case (cur_mode)
            MODE_VALID: begin
                first_lag = n2 - 1;
                run_len = n1 - n2 + 1;
            end
            MODE_SAME: begin
                first_lag = (len_a < len_v) ? n2 / 2 : n2 - 1 - n2 / 2;
                run_len = n1;
            end
            default: begin
                first_lag = 0;
                run_len = len_a + len_v - 1;
            end
        endcase
        for (m = 0; m < run_len; m++) begin
            acc = 0;
            for (j = 0; j < len_a; j++) begin
                vi = j - (first_lag + m) + len_v - 1;
                if (vi >= 0 && vi < len_v) begin
                    acc += longint'(samples_a[j]) * longint'(samples_v[vi]);
                end
            end
            r.corr_value = acc[VALUE_W-1:0];
            r.lag_index  = m[LAG_IDX_W-1:0];
            r.run_last   = (m + 1 == run_len);
            r.truncated  = dropped_any;
            exp_corr_q.push_back(r);
        end
        run_count++;
        if (dropped_any) begin
            trunc_run_count++;
        end
        len_a = 0;
        len_v = 0;
        ended_a = 1'b0;
        ended_v = 1'b0;
        dropped_any = 1'b0;
    endfunction

    // Apply one accepted request to the predictor.
    function automatic void corr_accept(input t_in_item it);
        if (it.req_type == REQ_SEQ_V) begin
            if (!ended_v) begin
                if (len_v < MAX_LEN) begin
                    samples_v[len_v] = it.sample;
                    len_v++;
                end else begin
                    dropped_any = 1'b1;
                end
                ended_v = it.seq_last;
            end
        end else begin
            if (!ended_a) begin
                if (len_a < MAX_LEN) begin
                    samples_a[len_a] = it.sample;
                    len_a++;
                end else begin
                    dropped_any = 1'b1;
                end
                ended_a = it.seq_last;
            end
        end
        if (ended_a && ended_v) begin
            emit_corr_run();
        end
    endfunction

    // Send one request; valid stays high afterwards unless the next request idles first.
    task automatic send_req(input logic typ, input logic signed [SAMPLE_IN_W-1:0] smp,
                            input logic last);
        t_in_item it;
        it.req_type = typ;
        it.sample   = smp;
        it.seq_last = last;
        while ($urandom_range(99) < src_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        corr_accept(it);
        req_count++;
    endtask

    // One APB transfer, setup then access, after which psel and penable are dropped.
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_CORR_MODE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected result is in, then let the datapath settle.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (exp_corr_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (MAX_LEN + 8) @(posedge i_clk);
    endtask

    // Mode changes only while idle; the new value is read back.
    task automatic write_corr_mode(input logic [1:0] mode);
        logic [APB_DATA_W-1:0] rd;
        drain_results();
        apb_access(1'b1, APB_DATA_W'(mode), rd);
        cur_mode = mode;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(mode)) begin
            report_mismatch("corr_mode readback", -1, longint'(rd), longint'(mode));
        end
    endtask

    function automatic logic signed [SAMPLE_IN_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return SAMPLE_IN_W'($urandom);
        endcase
    endfunction

    // Mostly short sequences, some up to the store depth, a few that overflow it.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) begin
            return $urandom_range(6, 1);
        end else if (r < 93) begin
            return $urandom_range(MAX_LEN, 7);
        end
        return $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
    endfunction

    // One random pair, interleaved, with occasional requests to an already ended sequence.
    task automatic send_random_pair(inout int n_sent);
        int want_a;
        int want_v;
        int sent_a;
        int sent_v;
        want_a = pick_len();
        want_v = pick_len();
        sent_a = 0;
        sent_v = 0;
        while (sent_a < want_a || sent_v < want_v) begin
            if (sent_a == want_a && $urandom_range(9) == 0) begin
                send_req(REQ_SEQ_A, pick_sample(), 1'($urandom));
            end else if (sent_v == want_v && $urandom_range(9) == 0) begin
                send_req(REQ_SEQ_V, pick_sample(), 1'($urandom));
            end else if (sent_v == want_v || (sent_a < want_a && $urandom_range(1) == 0)) begin
                sent_a++;
                send_req(REQ_SEQ_A, pick_sample(), sent_a == want_a);
                n_sent++;
            end else begin
                sent_v++;
                send_req(REQ_SEQ_V, pick_sample(), sent_v == want_v);
                n_sent++;
            end
        end
    endtask

    // Reset value of the mode, extreme samples, and a request after its sequence ended.
    task automatic test_valid_extremes();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(MODE_VALID)) begin
            report_mismatch("corr_mode after reset", -1, longint'(rd), longint'(MODE_VALID));
        end
        send_req(REQ_SEQ_A, 16'sh7fff, 1'b0);
        send_req(REQ_SEQ_A, 16'sh8000, 1'b1);
        send_req(REQ_SEQ_A, -16'sd1, 1'b1);
        send_req(REQ_SEQ_V, 16'sh8000, 1'b0);
        send_req(REQ_SEQ_V, 16'sh8000, 1'b0);
        send_req(REQ_SEQ_V, 16'sh7fff, 1'b1);
    endtask

    // Same mode with a longer than v, so the window starts on the other side.
    task automatic test_same_longer_a();
        write_corr_mode(MODE_SAME);
        send_req(REQ_SEQ_A, 16'sh5555, 1'b0);
        send_req(REQ_SEQ_V, 16'sh2aaa, 1'b0);
        send_req(REQ_SEQ_A, -16'sd1, 1'b0);
        send_req(REQ_SEQ_V, 16'sh7fff, 1'b1);
        send_req(REQ_SEQ_A, 16'sh8000, 1'b1);
    endtask

    // Full mode on the shortest possible pair.
    task automatic test_full_single();
        write_corr_mode(MODE_FULL);
        send_req(REQ_SEQ_V, 16'sh8000, 1'b1);
        send_req(REQ_SEQ_A, 16'sh8000, 1'b1);
    endtask

    // The unused mode code must give the full window.
    task automatic test_unused_mode();
        write_corr_mode(MODE_UNUSED);
        send_req(REQ_SEQ_A, 16'sh1234, 1'b0);
        send_req(REQ_SEQ_A, -16'sd300, 1'b1);
        send_req(REQ_SEQ_V, 16'sh7fff, 1'b0);
        send_req(REQ_SEQ_V, 16'sh0001, 1'b1);
    endtask

    // Longest run and largest sum; the last mark of a rides on a dropped element.
    task automatic test_overflow();
        int i;
        write_corr_mode(MODE_FULL);
        for (i = 0; i < MAX_LEN + 2; i++) begin
            send_req(REQ_SEQ_A, 16'sh8000, i == MAX_LEN + 1);
        end
        for (i = 0; i < MAX_LEN; i++) begin
            send_req(REQ_SEQ_V, 16'sh8000, i == MAX_LEN - 1);
        end
    endtask

    // Random pairs under one mode and one pacing mix.
    task automatic test_random_pairs(input int gap_pct, input int stall_pct,
                                     input logic [1:0] mode, input int n_items);
        int n_sent;
        write_corr_mode(mode);
        src_gap_pct = gap_pct;
        snk_stall_pct = stall_pct;
        n_sent = 0;
        while (n_sent < n_items) begin
            send_random_pair(n_sent);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result sink: ready follows the current stall rate.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            result_count++;
            if (exp_corr_q.size() == 0) begin
                report_mismatch("result with nothing pending", int'(got.lag_index),
                                longint'(got.corr_value), 0);
            end else begin
                want = exp_corr_q.pop_front();
                if (got.corr_value !== want.corr_value) begin
                    report_mismatch("corr_value", int'(want.lag_index),
                                    longint'(got.corr_value), longint'(want.corr_value));
                end
                if (got.lag_index !== want.lag_index) begin
                    report_mismatch("lag_index", int'(want.lag_index),
                                    longint'(got.lag_index), longint'(want.lag_index));
                end
                if (got.run_last !== want.run_last) begin
                    report_mismatch("run_last", int'(want.lag_index),
                                    longint'(got.run_last), longint'(want.run_last));
                end
                if (got.truncated !== want.truncated) begin
                    report_mismatch("truncated", int'(want.lag_index),
                                    longint'(got.truncated), longint'(want.truncated));
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Timeout with %0d results still pending", exp_corr_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_valid_extremes();
        test_same_longer_a();
        test_full_single();
        test_unused_mode();
        test_overflow();
        test_random_pairs(0, 0, MODE_VALID, 40);
        test_random_pairs(50, 0, MODE_SAME, 40);
        test_random_pairs(0, 50, MODE_FULL, 40);
        test_random_pairs(11, 11, MODE_UNUSED, 40);
        test_random_pairs(11, 11, MODE_SAME, 40);
        drain_results();

        $display("Covered %0d requests and %0d results over %0d runs, %0d of them truncated.",
                 req_count, result_count, run_count, trunc_run_count);
        $display("All four mode codes ran with free, gapped, stalled and mixed pacing.");
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", err_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/scc_pkg.sv
hw/rtl/scc_in_if.sv
hw/rtl/scc_out_if.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_dpath.sv
hw/rtl/sequence_cross_correlation_unit.sv
sim/sequence_cross_correlation_unit_tb.sv
